// ===== hdl/blest_pkg.sv =====
package blest_pkg;

  // Field widths
  localparam int ADC_W      = 12;
  localparam int OFS_W      = 10;
  localparam int LVL_W      = 7;
  localparam int VOLT_W     = 14;
  localparam int RUN_W      = 3;
  localparam int SRC_W      = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int CORR_W     = 14;  // signed corrected sample

  // Shared multiply-divide unit
  localparam int MUL_A_W = 12;
  localparam int MUL_B_W = 18;
  localparam int NUM_W   = 32;
  localparam int DEN_W   = 21;     // holds full scale * bottom resistor at the top of its range

  // Divider network and reference
  localparam int VREF_MV    = 3300;
  localparam int RES_TOP    = 33;
  localparam int RES_BOTTOM = 20;
  localparam logic [MUL_B_W-1:0] VOLT_SCALE = MUL_B_W'(VREF_MV * (RES_TOP + RES_BOTTOM));
  localparam logic [VOLT_W-1:0]  VOLT_MAX   = 14'd16383;

  // Level curve
  localparam logic [MUL_B_W-1:0] KNEE_COEF  = 18'd15;
  localparam logic [MUL_B_W-1:0] UPPER_COEF = 18'd85;
  localparam logic [LVL_W-1:0]   KNEE_PCT       = 7'd15;
  localparam logic [LVL_W-1:0]   CHARGE_MAX_PCT = 7'd99;
  localparam logic [LVL_W-1:0]   LOW_HOLD_PCT   = 7'd16;
  localparam logic [LVL_W-1:0]   FULL_PCT       = 7'd100;
  localparam logic [RUN_W-1:0]   RUN_MAX        = 3'd7;

  // Charger source codes
  localparam logic [SRC_W-1:0] SRC_BATTERY   = 2'd0;
  localparam logic [SRC_W-1:0] SRC_USB       = 2'd1;
  localparam logic [SRC_W-1:0] SRC_MAINS     = 2'd2;
  localparam logic [SRC_W-1:0] SRC_DISCHARGE = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_NOT_CHARGING = 2'd0;
  localparam logic [STAT_W-1:0] ST_CHARGING     = 2'd1;
  localparam logic [STAT_W-1:0] ST_DISCHARGING  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL         = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FULL_ADC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_ADC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ADC     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_FLOOR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FAKE        = 3'd7;

  typedef struct packed {
    logic [ADC_W-1:0] full_adc;
    logic [ADC_W-1:0] empty_adc;
    logic [ADC_W-1:0] low_adc;
    logic [ADC_W-1:0] split;
    logic [OFS_W-1:0] offset_high;
    logic [OFS_W-1:0] offset_low;
    logic [ADC_W-1:0] valid_floor;
    logic             fake_battery;
  } cfg_regs_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [DEN_W-1:0]   den;
  } mdu_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } mdu_rsp_t;

endpackage

// ===== hdl/battery_level_estimator_unit.sv =====
// Battery level estimator.
// Input channel: in_adc_sample, in_charge_pin_a, in_charge_pin_b with
// in_valid / in_stall; one item per poll tick is transferred when in_valid is
// high and in_stall is low. Result channel: out_level_pct, out_voltage_mv,
// out_sample_valid, out_on_mains, out_battery_full, out_charge_status with
// out_valid / out_stall; exactly one result per input item, in order.
// Thresholds are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
// A sample above the valid floor is converted to millivolts and then to a
// level; a sample at or below the floor goes straight to the result. One shared
// multiplier feeding a 32-step restoring divider runs up to twice per item
// (millivolts, then the level slope); in_stall stays high until the item is done.
// The result sits in an output register: the next item is taken while it waits,
// but the following result is held back as long as out_stall keeps it there.
// Reset (synchronous, rst_n low) restores the default thresholds, clears the
// level, voltage, run counters and full flag, sets the source to battery only
// and drops out_valid.
module battery_level_estimator_unit #(
  parameter int ADC_FULL_SCALE = 4096,
  parameter int ZERO_CONFIRM   = 6,
  parameter int LOW_CONFIRM    = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [blest_pkg::ADC_W-1:0]       in_adc_sample,
  input  logic                              in_charge_pin_a,
  input  logic                              in_charge_pin_b,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [blest_pkg::LVL_W-1:0]       out_level_pct,
  output logic [blest_pkg::VOLT_W-1:0]      out_voltage_mv,
  output logic                              out_sample_valid,
  output logic                              out_on_mains,
  output logic                              out_battery_full,
  output logic [blest_pkg::STAT_W-1:0]      out_charge_status,
  input  logic                              cfg_we,
  input  logic [blest_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blest_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import blest_pkg::*;

  localparam logic [DEN_W-1:0] VOLT_DIV = DEN_W'(ADC_FULL_SCALE * RES_BOTTOM);
  localparam logic [RUN_W-1:0] ZERO_RUN_MIN = RUN_W'(ZERO_CONFIRM);
  localparam logic [RUN_W-1:0] LOW_RUN_MIN  = RUN_W'(LOW_CONFIRM);

  typedef enum logic [2:0] {
    S_IDLE, S_VOLT_GO, S_VOLT_WAIT, S_LVL_GO, S_LVL_WAIT, S_POST
  } state_t;

  cfg_regs_t regs;
  mdu_req_t  mreq;
  mdu_rsp_t  mrsp;
  logic      mdu_busy;

  blest_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  blest_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp),
    .busy  (mdu_busy)
  );

  state_t state_r, state_nxt;

  // item working registers
  logic [ADC_W-1:0]  sample_r, sample_nxt;
  logic              pin_a_r, pin_a_nxt, pin_b_r, pin_b_nxt;
  logic              valid_r, valid_nxt;
  logic              mains_r, mains_nxt;
  logic              upper_r, upper_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [VOLT_W-1:0] volt_r, volt_nxt;

  // persistent state
  logic [LVL_W-1:0]  prev_r, prev_nxt;
  logic [RUN_W-1:0]  zero_run_r, zero_run_nxt;
  logic [RUN_W-1:0]  low_run_r, low_run_nxt;
  logic [LVL_W-1:0]  held_lvl_r, held_lvl_nxt;
  logic [VOLT_W-1:0] held_volt_r, held_volt_nxt;
  logic [SRC_W-1:0]  src_r, src_nxt;
  logic              full_r, full_nxt;

  // output register
  logic              ov_r, ov_nxt;
  logic [LVL_W-1:0]  o_lvl_r, o_lvl_nxt;
  logic [VOLT_W-1:0] o_volt_r, o_volt_nxt;
  logic              o_sv_r, o_sv_nxt;
  logic              o_mains_r, o_mains_nxt;
  logic              o_full_r, o_full_nxt;
  logic [STAT_W-1:0] o_stat_r, o_stat_nxt;

  // datapath
  logic signed [CORR_W-1:0] adc_v, adc_c, full_s, empty_s, low_s;
  logic [OFS_W-1:0]         corr_ofs;
  logic signed [CORR_W-1:0] up_num, lo_num;
  logic [LVL_W-1:0]         prev_eff, lv;
  logic [RUN_W-1:0]         zr, lr;
  logic [LVL_W-1:0]         held_eff, held_fin;
  logic                     hw_full, new_mains, full_fin;
  logic                     out_free;

  assign full_s   = $signed({2'b00, regs.full_adc});
  assign empty_s  = $signed({2'b00, regs.empty_adc});
  assign low_s    = $signed({2'b00, regs.low_adc});
  assign adc_v    = mains_r ? $signed({2'b00, sample_r}) - $signed({4'b0, regs.offset_high})
                            : $signed({2'b00, sample_r});
  assign corr_ofs = (sample_r < regs.split) ? regs.offset_low : regs.offset_high;
  assign adc_c    = mains_r ? $signed({2'b00, sample_r}) - $signed({4'b0, corr_ofs})
                            : $signed({2'b00, sample_r});
  assign up_num   = adc_c - low_s;
  assign lo_num   = adc_c - empty_s;
  assign out_free = !ov_r || !out_stall;

  // level filter on the fresh level (charging clamp, zero and low-run confirmation)
  always_comb begin
    prev_eff = (prev_r == '0) ? lvl_r : prev_r;
    lv       = lvl_r;
    zr       = zero_run_r;
    lr       = low_run_r;
    if (mains_r) begin
      if (lv >= FULL_PCT) lv = CHARGE_MAX_PCT;
      if (lv == '0) lv = 7'd1;
      if (lv < prev_eff) lv = prev_eff;
    end
    if (lv == '0) begin
      zr = (zero_run_r == RUN_MAX) ? RUN_MAX : zero_run_r + 1'b1;
      lv = (zr >= ZERO_RUN_MIN) ? 7'd0 : 7'd1;
    end else begin
      zr = '0;
      if (lv <= KNEE_PCT) lr = (low_run_r == RUN_MAX) ? RUN_MAX : low_run_r + 1'b1;
      else lr = '0;
    end
    if (!mains_r && lr < LOW_RUN_MIN && lv <= KNEE_PCT && lv > 7'd1) lv = LOW_HOLD_PCT;
    if (regs.fake_battery) lv = FULL_PCT;

    hw_full   = !pin_a_r && pin_b_r;
    new_mains = pin_a_r ^ pin_b_r;
    held_eff  = valid_r ? lv : held_lvl_r;
    full_fin  = hw_full || (held_eff >= FULL_PCT);
    held_fin  = hw_full ? FULL_PCT : held_eff;
  end

  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    pin_a_nxt     = pin_a_r;
    pin_b_nxt     = pin_b_r;
    valid_nxt     = valid_r;
    mains_nxt     = mains_r;
    upper_nxt     = upper_r;
    lvl_nxt       = lvl_r;
    volt_nxt      = volt_r;
    prev_nxt      = prev_r;
    zero_run_nxt  = zero_run_r;
    low_run_nxt   = low_run_r;
    held_lvl_nxt  = held_lvl_r;
    held_volt_nxt = held_volt_r;
    src_nxt       = src_r;
    full_nxt      = full_r;
    ov_nxt        = ov_r && out_stall;
    o_lvl_nxt     = o_lvl_r;
    o_volt_nxt    = o_volt_r;
    o_sv_nxt      = o_sv_r;
    o_mains_nxt   = o_mains_r;
    o_full_nxt    = o_full_r;
    o_stat_nxt    = o_stat_r;
    mreq.start    = 1'b0;
    mreq.mul_a    = '0;
    mreq.mul_b    = '0;
    mreq.den      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_adc_sample;
          pin_a_nxt  = in_charge_pin_a;
          pin_b_nxt  = in_charge_pin_b;
          valid_nxt  = in_adc_sample > regs.valid_floor;
          mains_nxt  = src_r == SRC_MAINS;
          state_nxt  = (in_adc_sample > regs.valid_floor) ? S_VOLT_GO : S_POST;
        end
      end
      S_VOLT_GO: begin
        mreq.start = 1'b1;
        mreq.mul_a = (adc_v > 0) ? adc_v[ADC_W-1:0] : '0;
        mreq.mul_b = VOLT_SCALE;
        mreq.den   = VOLT_DIV;
        state_nxt  = S_VOLT_WAIT;
      end
      S_VOLT_WAIT: begin
        if (mrsp.done) begin
          volt_nxt  = (mrsp.quot > NUM_W'(VOLT_MAX)) ? VOLT_MAX : mrsp.quot[VOLT_W-1:0];
          state_nxt = S_LVL_GO;
        end
      end
      S_LVL_GO: begin
        // thresholds tested in order: full first, then empty, slope between
        if (adc_c >= full_s) begin
          lvl_nxt   = FULL_PCT;
          state_nxt = S_POST;
        end else if (adc_c <= empty_s) begin
          lvl_nxt   = '0;
          state_nxt = S_POST;
        end else begin
          mreq.start = 1'b1;
          upper_nxt  = adc_c >= low_s;
          if (adc_c >= low_s) begin
            mreq.mul_a = up_num[ADC_W-1:0];
            mreq.mul_b = UPPER_COEF;
            mreq.den   = DEN_W'(regs.full_adc - regs.low_adc);
          end else begin
            mreq.mul_a = lo_num[ADC_W-1:0];
            mreq.mul_b = KNEE_COEF;
            mreq.den   = DEN_W'(regs.low_adc - regs.empty_adc);
          end
          state_nxt = S_LVL_WAIT;
        end
      end
      S_LVL_WAIT: begin
        if (mrsp.done) begin
          lvl_nxt   = mrsp.quot[LVL_W-1:0] + (upper_r ? KNEE_PCT : 7'd0);
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (out_free) begin
          if (valid_r) begin
            prev_nxt      = lv;
            zero_run_nxt  = zr;
            low_run_nxt   = lr;
            held_volt_nxt = volt_r;
          end
          held_lvl_nxt = held_fin;
          src_nxt      = new_mains ? SRC_MAINS : SRC_DISCHARGE;
          full_nxt     = full_fin;
          ov_nxt       = 1'b1;
          o_lvl_nxt    = held_fin;
          o_volt_nxt   = valid_r ? volt_r : held_volt_r;
          o_sv_nxt     = valid_r;
          o_mains_nxt  = new_mains;
          o_full_nxt   = full_fin;
          if (new_mains) o_stat_nxt = (held_fin == FULL_PCT && full_fin) ? ST_FULL : ST_CHARGING;
          else o_stat_nxt = ST_DISCHARGING;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      zero_run_r  <= '0;
      low_run_r   <= '0;
      held_lvl_r  <= '0;
      held_volt_r <= '0;
      src_r       <= SRC_BATTERY;
      full_r      <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      zero_run_r  <= zero_run_nxt;
      low_run_r   <= low_run_nxt;
      held_lvl_r  <= held_lvl_nxt;
      held_volt_r <= held_volt_nxt;
      src_r       <= src_nxt;
      full_r      <= full_nxt;
      ov_r        <= ov_nxt;
    end
    sample_r  <= sample_nxt;
    pin_a_r   <= pin_a_nxt;
    pin_b_r   <= pin_b_nxt;
    valid_r   <= valid_nxt;
    mains_r   <= mains_nxt;
    upper_r   <= upper_nxt;
    lvl_r     <= lvl_nxt;
    volt_r    <= volt_nxt;
    o_lvl_r   <= o_lvl_nxt;
    o_volt_r  <= o_volt_nxt;
    o_sv_r    <= o_sv_nxt;
    o_mains_r <= o_mains_nxt;
    o_full_r  <= o_full_nxt;
    o_stat_r  <= o_stat_nxt;
  end

  assign in_stall          = state_r != S_IDLE;
  assign out_valid         = ov_r;
  assign out_level_pct     = o_lvl_r;
  assign out_voltage_mv    = o_volt_r;
  assign out_sample_valid  = o_sv_r;
  assign out_on_mains      = o_mains_r;
  assign out_battery_full  = o_full_r;
  assign out_charge_status = o_stat_r;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("input taken without going busy");
  a_mdu_idle_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE || state_r == S_POST |-> !mdu_busy)
    else $error("divider running outside a compute state");
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level_pct <= FULL_PCT) else $error("level above 100");
  a_status_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_on_mains != (out_charge_status == ST_DISCHARGING))
    else $error("status disagrees with source");
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_charge_status == ST_FULL |-> out_battery_full)
    else $error("full status without full flag");

endmodule

// ===== hdl/blest_cfg.sv =====
module blest_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [blest_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [blest_pkg::CFG_DATA_W-1:0]    cfg_data,
  output blest_pkg::cfg_regs_t                regs
);
  import blest_pkg::*;

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.full_adc     <= 12'd3747;
      regs_r.empty_adc    <= 12'd2903;
      regs_r.low_adc      <= 12'd3091;
      regs_r.split        <= 12'd3300;
      regs_r.offset_high  <= 10'd90;
      regs_r.offset_low   <= 10'd160;
      regs_r.valid_floor  <= 12'd1000;
      regs_r.fake_battery <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FULL_ADC:    regs_r.full_adc     <= cfg_data[ADC_W-1:0];
        REG_EMPTY_ADC:   regs_r.empty_adc    <= cfg_data[ADC_W-1:0];
        REG_LOW_ADC:     regs_r.low_adc      <= cfg_data[ADC_W-1:0];
        REG_SPLIT:       regs_r.split        <= cfg_data[ADC_W-1:0];
        REG_OFFSET_HIGH: regs_r.offset_high  <= cfg_data[OFS_W-1:0];
        REG_OFFSET_LOW:  regs_r.offset_low   <= cfg_data[OFS_W-1:0];
        REG_VALID_FLOOR: regs_r.valid_floor  <= cfg_data[ADC_W-1:0];
        REG_FAKE:        regs_r.fake_battery <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

// ===== hdl/blest_mdu.sv =====
module blest_mdu (
  input  logic                clk,
  input  logic                rst_n,
  input  blest_pkg::mdu_req_t req,
  output blest_pkg::mdu_rsp_t rsp,
  output logic                busy
);
  import blest_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [NUM_W-1:0]           num_r;   // dividend shifting out, quotient shifting in
  logic [DEN_W-1:0]           rem_r;
  logic [DEN_W-1:0]           den_r;
  logic [MUL_A_W+MUL_B_W-1:0] prod;
  logic [DEN_W:0]             trial;
  logic [DEN_W:0]             diff;
  logic                       ge;

  assign prod  = req.mul_a * req.mul_b;
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= NUM_W'(prod);
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;
  assign busy     = busy_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("mdu started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("mdu done without a run");
  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == '0 && !req.start |=> done_r && !busy_r)
    else $error("mdu final step did not finish");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("mdu done longer than one cycle");

endmodule
